### rtl/qrm_pkg.sv
package qrm_pkg;

  // default component width, signed fixed point with width - 2 fraction bits
  localparam int COMP_WIDTH_DEF = 16;

  // register stages from input transfer to output register
  localparam int STAGES = 7;

  typedef logic [STAGES-1:0] stage_vec_t;

  // operation codes
  localparam logic OP_ROTATE   = 1'b0;
  localparam logic OP_MULTIPLY = 1'b1;

  // configuration register map, word index
  localparam int        ADDR_W   = 4;
  localparam int        DATA_W   = 32;
  localparam logic [1:0] REG_Q_W = 2'd0;
  localparam logic [1:0] REG_Q_X = 2'd1;
  localparam logic [1:0] REG_Q_Y = 2'd2;
  localparam logic [1:0] REG_Q_Z = 2'd3;

  // second product t * conj(q): for rotated x, y, z (rows) and t term (column),
  // which q component multiplies and whether the term is subtracted
  localparam int ROT_QIDX [3][4] = '{'{1, 0, 3, 2}, '{2, 3, 0, 1}, '{3, 2, 1, 0}};
  localparam bit ROT_NEG  [3][4] = '{'{1, 0, 1, 0}, '{1, 0, 0, 1}, '{1, 1, 0, 0}};

endpackage

### rtl/qrm_quat_mult.sv
module qrm_quat_mult #(
  parameter int COMPONENT_WIDTH = qrm_pkg::COMP_WIDTH_DEF
) (
  input  logic                              clk,
  input  qrm_pkg::stage_vec_t               stage_en,
  input  logic                              op_i,
  input  logic signed [COMPONENT_WIDTH-1:0] p_w_i,
  input  logic signed [COMPONENT_WIDTH-1:0] p_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] p_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] p_z_i,
  input  logic signed [COMPONENT_WIDTH-1:0] q_i [4],
  output logic                              op_o,
  output logic signed [2*COMPONENT_WIDTH+1:0] t_o [4]
);

  localparam int W  = COMPONENT_WIDTH;
  localparam int PW = 2 * W;
  localparam int TW = 2 * W + 2;

  logic signed [W-1:0]  p_vec [4];
  logic signed [PW-1:0] prod1_r [4][4];
  logic                 op1_r;
  logic signed [TW-1:0] t_nxt [4];
  logic signed [TW-1:0] t_r [4];
  logic                 op2_r;

  // rotate uses the pure vector (0, v)
  always_comb begin
    p_vec[0] = (op_i == qrm_pkg::OP_MULTIPLY) ? p_w_i : '0;
    p_vec[1] = p_x_i;
    p_vec[2] = p_y_i;
    p_vec[3] = p_z_i;
  end

  // stage 1: all sixteen component products
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      op1_r <= op_i;
      for (int a = 0; a < 4; a++) begin
        for (int b = 0; b < 4; b++) begin
          prod1_r[a][b] <= PW'(q_i[a]) * PW'(p_vec[b]);
        end
      end
    end
  end

  // hamilton product q * p
  always_comb begin
    t_nxt[0] = TW'(prod1_r[0][0]) - TW'(prod1_r[1][1])
             - TW'(prod1_r[2][2]) - TW'(prod1_r[3][3]);
    t_nxt[1] = TW'(prod1_r[0][1]) + TW'(prod1_r[1][0])
             + TW'(prod1_r[2][3]) - TW'(prod1_r[3][2]);
    t_nxt[2] = TW'(prod1_r[0][2]) - TW'(prod1_r[1][3])
             + TW'(prod1_r[2][0]) + TW'(prod1_r[3][1]);
    t_nxt[3] = TW'(prod1_r[0][3]) + TW'(prod1_r[1][2])
             - TW'(prod1_r[2][1]) + TW'(prod1_r[3][0]);
  end

  // stage 2: full-width sums
  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      op2_r <= op1_r;
      for (int k = 0; k < 4; k++) begin
        t_r[k] <= t_nxt[k];
      end
    end
  end

  assign op_o = op2_r;
  assign t_o  = t_r;

endmodule

### rtl/qrm_conj_mult.sv
module qrm_conj_mult #(
  parameter int COMPONENT_WIDTH = qrm_pkg::COMP_WIDTH_DEF
) (
  input  logic                                clk,
  input  qrm_pkg::stage_vec_t                 stage_en,
  input  logic                                op_i,
  input  logic signed [2*COMPONENT_WIDTH+1:0] t_i [4],
  input  logic signed [COMPONENT_WIDTH-1:0]   q_i [4],
  output logic                                op_o,
  output logic signed [3*COMPONENT_WIDTH+2:0] acc_o [4]
);

  localparam int W  = COMPONENT_WIDTH;
  localparam int TW = 2 * W + 2;
  localparam int HW = 2 * W + 2;
  localparam int LW = 2 * W + 1;
  localparam int RW = 3 * W + 3;

  logic signed [HW-1:0] hi3_r [3][4];
  logic signed [LW-1:0] lo3_r [3][4];
  logic signed [TW-1:0] t3_r [4];
  logic                 op3_r;
  logic signed [RW-1:0] prod4_r [3][4];
  logic signed [TW-1:0] t4_r [4];
  logic                 op4_r;
  logic signed [RW-1:0] acc_nxt [4];
  logic signed [RW-1:0] acc_r [4];
  logic                 op5_r;

  // stage 3: each t * q term split into a signed high and unsigned low partial
  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      op3_r <= op_i;
      for (int j = 0; j < 4; j++) begin
        t3_r[j] <= t_i[j];
      end
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 4; j++) begin
          hi3_r[k][j] <= HW'($signed(t_i[j][TW-1:W]))
                       * HW'(q_i[2'(qrm_pkg::ROT_QIDX[k][j])]);
          lo3_r[k][j] <= LW'($signed({1'b0, t_i[j][W-1:0]}))
                       * LW'(q_i[2'(qrm_pkg::ROT_QIDX[k][j])]);
        end
      end
    end
  end

  // stage 4: recombine partials into full products
  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      op4_r <= op3_r;
      for (int j = 0; j < 4; j++) begin
        t4_r[j] <= t3_r[j];
      end
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 4; j++) begin
          prod4_r[k][j] <= (RW'(hi3_r[k][j]) <<< W) + RW'(lo3_r[k][j]);
        end
      end
    end
  end

  // signed sums for rotate, first product passes through for multiply
  always_comb begin
    logic signed [RW-1:0] sum;
    acc_nxt[0] = (op4_r == qrm_pkg::OP_MULTIPLY) ? RW'(t4_r[0]) : '0;
    for (int k = 0; k < 3; k++) begin
      sum = '0;
      for (int j = 0; j < 4; j++) begin
        if (qrm_pkg::ROT_NEG[k][j]) begin
          sum = sum - prod4_r[k][j];
        end else begin
          sum = sum + prod4_r[k][j];
        end
      end
      acc_nxt[k+1] = (op4_r == qrm_pkg::OP_MULTIPLY) ? RW'(t4_r[k+1]) : sum;
    end
  end

  // stage 5
  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      op5_r <= op4_r;
      for (int k = 0; k < 4; k++) begin
        acc_r[k] <= acc_nxt[k];
      end
    end
  end

  assign op_o  = op5_r;
  assign acc_o = acc_r;

endmodule

### rtl/qrm_round_sat.sv
module qrm_round_sat #(
  parameter int COMPONENT_WIDTH = qrm_pkg::COMP_WIDTH_DEF
) (
  input  logic                                clk,
  input  qrm_pkg::stage_vec_t                 stage_en,
  input  logic                                op_i,
  input  logic signed [3*COMPONENT_WIDTH+2:0] acc_i [4],
  output logic signed [COMPONENT_WIDTH-1:0]   comp_o [4],
  output logic                                sat_o
);

  localparam int W    = COMPONENT_WIDTH;
  localparam int FRAC = W - 2;
  localparam int RW   = 3 * W + 3;
  localparam logic signed [RW-1:0] HALF_MUL = RW'(1) <<< (FRAC - 1);
  localparam logic signed [RW-1:0] HALF_ROT = RW'(1) <<< (2 * FRAC - 1);
  localparam logic signed [RW-1:0] SAT_MAX  = (RW'(1) <<< (W - 1)) - RW'(1);
  localparam logic signed [RW-1:0] SAT_MIN  = -SAT_MAX - RW'(1);

  logic signed [RW-1:0] sum [4];
  logic signed [RW-1:0] rnd_nxt [4];
  logic signed [RW-1:0] rnd_r [4];
  logic signed [W-1:0]  comp_nxt [4];
  logic                 sat_nxt;
  logic signed [W-1:0]  comp_r [4];
  logic                 sat_r;

  // round half up, shift depends on the operation
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (op_i == qrm_pkg::OP_MULTIPLY) begin
        sum[k]     = acc_i[k] + HALF_MUL;
        rnd_nxt[k] = sum[k] >>> FRAC;
      end else begin
        sum[k]     = acc_i[k] + HALF_ROT;
        rnd_nxt[k] = sum[k] >>> (2 * FRAC);
      end
    end
  end

  // stage 6
  always_ff @(posedge clk) begin
    if (stage_en[5]) begin
      for (int k = 0; k < 4; k++) begin
        rnd_r[k] <= rnd_nxt[k];
      end
    end
  end

  // clamp to the component range
  always_comb begin
    sat_nxt = 1'b0;
    for (int k = 0; k < 4; k++) begin
      if (rnd_r[k] > SAT_MAX) begin
        comp_nxt[k] = SAT_MAX[W-1:0];
        sat_nxt     = 1'b1;
      end else if (rnd_r[k] < SAT_MIN) begin
        comp_nxt[k] = SAT_MIN[W-1:0];
        sat_nxt     = 1'b1;
      end else begin
        comp_nxt[k] = rnd_r[k][W-1:0];
      end
    end
  end

  // stage 7: output register
  always_ff @(posedge clk) begin
    if (stage_en[6]) begin
      sat_r <= sat_nxt;
      for (int k = 0; k < 4; k++) begin
        comp_r[k] <= comp_nxt[k];
      end
    end
  end

  assign comp_o = comp_r;
  assign sat_o  = sat_r;

endmodule

### rtl/quaternion_rotate_and_multiply_unit.sv
// pipeline: the input transfer edge loads stage 1 of 7; out_valid comes from stage 7
// throughput: one item per cycle without output stalls; no feedback, one item per stage
// stalls: a stage loads whenever it is empty or the stage after it moves, so bubbles close up
// reset: rst_n synchronous, active low; clears all stage valid bits and loads q = (1, 0, 0, 0)
// configuration reads and writes take effect at once and are never blocked
module quaternion_rotate_and_multiply_unit #(
  parameter int COMPONENT_WIDTH = qrm_pkg::COMP_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic signed [COMPONENT_WIDTH-1:0] in_w,
  input  logic signed [COMPONENT_WIDTH-1:0] in_x,
  input  logic signed [COMPONENT_WIDTH-1:0] in_y,
  input  logic signed [COMPONENT_WIDTH-1:0] in_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [COMPONENT_WIDTH-1:0] out_w,
  output logic signed [COMPONENT_WIDTH-1:0] out_x,
  output logic signed [COMPONENT_WIDTH-1:0] out_y,
  output logic signed [COMPONENT_WIDTH-1:0] out_z,
  output logic                              out_saturated,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [qrm_pkg::ADDR_W-1:0]        paddr,
  input  logic [qrm_pkg::DATA_W-1:0]        pwdata,
  output logic [qrm_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  localparam int W  = COMPONENT_WIDTH;
  localparam int TW = 2 * W + 2;
  localparam int RW = 3 * W + 3;
  localparam int NS = qrm_pkg::STAGES;

  logic signed [W-1:0]  q_r [4];
  logic                 cfg_wr;
  logic [1:0]           cfg_idx;
  logic [NS-1:0]        valid_r;
  logic [NS-1:0]        valid_nxt;
  qrm_pkg::stage_vec_t  stage_en;
  logic                 op2;
  logic signed [TW-1:0] t2 [4];
  logic                 op5;
  logic signed [RW-1:0] acc5 [4];
  logic signed [W-1:0]  comp [4];

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r[0] <= W'(1) <<< (W - 2);
      q_r[1] <= '0;
      q_r[2] <= '0;
      q_r[3] <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        qrm_pkg::REG_Q_W: q_r[0] <= pwdata[W-1:0];
        qrm_pkg::REG_Q_X: q_r[1] <= pwdata[W-1:0];
        qrm_pkg::REG_Q_Y: q_r[2] <= pwdata[W-1:0];
        qrm_pkg::REG_Q_Z: q_r[3] <= pwdata[W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      qrm_pkg::REG_Q_W: prdata = qrm_pkg::DATA_W'(q_r[0]);
      qrm_pkg::REG_Q_X: prdata = qrm_pkg::DATA_W'(q_r[1]);
      qrm_pkg::REG_Q_Y: prdata = qrm_pkg::DATA_W'(q_r[2]);
      qrm_pkg::REG_Q_Z: prdata = qrm_pkg::DATA_W'(q_r[3]);
      default:          prdata = '0;
    endcase
  end

  // stage enables ripple back from the output register
  always_comb begin
    stage_en[NS-1] = ~valid_r[NS-1] | out_ready;
    for (int s = NS - 2; s >= 0; s--) begin
      stage_en[s] = ~valid_r[s] | stage_en[s+1];
    end
  end

  always_comb begin
    valid_nxt[0] = stage_en[0] ? in_valid : valid_r[0];
    for (int s = 1; s < NS; s++) begin
      valid_nxt[s] = stage_en[s] ? valid_r[s-1] : valid_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = stage_en[0];
  assign out_valid = valid_r[NS-1];

  // q * p
  qrm_quat_mult #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH)
  ) u_quat_mult (
    .clk      (clk),
    .stage_en (stage_en),
    .op_i     (in_operation),
    .p_w_i    (in_w),
    .p_x_i    (in_x),
    .p_y_i    (in_y),
    .p_z_i    (in_z),
    .q_i      (q_r),
    .op_o     (op2),
    .t_o      (t2)
  );

  // (q * v) * conj(q) for rotate; q * p passes through for multiply
  qrm_conj_mult #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH)
  ) u_conj_mult (
    .clk      (clk),
    .stage_en (stage_en),
    .op_i     (op2),
    .t_i      (t2),
    .q_i      (q_r),
    .op_o     (op5),
    .acc_o    (acc5)
  );

  // rounding, saturation and output register
  qrm_round_sat #(
    .COMPONENT_WIDTH(COMPONENT_WIDTH)
  ) u_round_sat (
    .clk      (clk),
    .stage_en (stage_en),
    .op_i     (op5),
    .acc_i    (acc5),
    .comp_o   (comp),
    .sat_o    (out_saturated)
  );

  assign out_w = comp[0];
  assign out_x = comp[1];
  assign out_y = comp[2];
  assign out_z = comp[3];

endmodule

### rtl/qrm_checker.sv
module qrm_checker #(
  parameter int COMPONENT_WIDTH = qrm_pkg::COMP_WIDTH_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [COMPONENT_WIDTH-1:0] out_w,
  input logic signed [COMPONENT_WIDTH-1:0] out_x,
  input logic signed [COMPONENT_WIDTH-1:0] out_y,
  input logic signed [COMPONENT_WIDTH-1:0] out_z,
  input logic                              out_saturated
);

  localparam int W = COMPONENT_WIDTH;
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // nothing comes out right after reset
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  // pipeline takes input whenever the output side can move
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input blocked with output side free");

  // a saturation flag comes with a clamped component
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_w == CMAX) || (out_w == CMIN) || (out_x == CMAX) || (out_x == CMIN) ||
      (out_y == CMAX) || (out_y == CMIN) || (out_z == CMAX) || (out_z == CMIN))
    else $error("saturation flag without clamped component");

endmodule

bind quaternion_rotate_and_multiply_unit qrm_checker #(
  .COMPONENT_WIDTH(COMPONENT_WIDTH)
) u_qrm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_w         (out_w),
  .out_x         (out_x),
  .out_y         (out_y),
  .out_z         (out_z),
  .out_saturated (out_saturated)
);

### dv/tb_quaternion_rotate_and_multiply_unit.sv
`timescale 1ns / 1ps

module tb_quaternion_rotate_and_multiply_unit;

  localparam int CW = qrm_pkg::COMP_WIDTH_DEF;
  localparam int FRAC = CW - 2;
  localparam longint COMP_MAX = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint COMP_MIN = -COMP_MAX - 1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 80;

  typedef struct {
    logic signed [CW-1:0] comp [4];
    logic                 sat;
  } quat_result_t;

  // mirror of the stored quaternion plus the queue of predicted results
  class quat_scoreboard;
    logic signed [CW-1:0] q [4];
    quat_result_t         pending [$];
    int                   errors;

    function new();
      q[0] = CW'(longint'(1) <<< FRAC);
      q[1] = '0;
      q[2] = '0;
      q[3] = '0;
      errors = 0;
    endfunction

    function void set_component(int idx, logic signed [CW-1:0] value);
      q[idx] = value;
    endfunction

    // r = a * b, components ordered w, x, y, z
    function void hamilton(input longint a [4], input longint b [4], output longint r [4]);
      r[0] = a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3];
      r[1] = a[0] * b[1] + a[1] * b[0] + a[2] * b[3] - a[3] * b[2];
      r[2] = a[0] * b[2] - a[1] * b[3] + a[2] * b[0] + a[3] * b[1];
      r[3] = a[0] * b[3] + a[1] * b[2] - a[2] * b[1] + a[3] * b[0];
    endfunction

    // round half up by s bits, then clamp to the component range
    function logic signed [CW-1:0] round_sat(longint v, int s, inout bit flag);
      longint r;
      r = (v + (longint'(1) <<< (s - 1))) >>> s;
      if (r > COMP_MAX) begin
        flag = 1'b1;
        r = COMP_MAX;
      end else if (r < COMP_MIN) begin
        flag = 1'b1;
        r = COMP_MIN;
      end
      return r[CW-1:0];
    endfunction

    // rotate: q * (0, v) * conj(q); multiply: q * p
    function quat_result_t rotate_or_multiply(logic op, logic signed [CW-1:0] p [4]);
      longint       qa [4];
      longint       b [4];
      longint       t [4];
      longint       r [4];
      quat_result_t res;
      bit           flag;
      int           first;
      int           shift;
      for (int i = 0; i < 4; i++) qa[i] = q[i];
      for (int i = 1; i < 4; i++) b[i] = p[i];
      if (op == qrm_pkg::OP_ROTATE) begin
        b[0] = 0;
        hamilton(qa, b, t);
        b[0] = q[0];
        for (int i = 1; i < 4; i++) b[i] = -longint'(q[i]);
        hamilton(t, b, r);
        shift = 2 * FRAC;
        first = 1;
        res.comp[0] = '0;
      end else begin
        b[0] = p[0];
        hamilton(qa, b, r);
        shift = FRAC;
        first = 0;
      end
      flag = 1'b0;
      for (int i = first; i < 4; i++) res.comp[i] = round_sat(r[i], shift, flag);
      res.sat = flag;
      return res;
    endfunction

    function void note_input(logic op, logic signed [CW-1:0] p [4]);
      pending.push_back(rotate_or_multiply(op, p));
    endfunction

    function void check_result(quat_result_t got);
      quat_result_t exp;
      string        names [4];
      names = '{"w", "x", "y", "z"};
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing pending, expected none actual x %0d",
                 $time, got.comp[1]);
        return;
      end
      exp = pending.pop_front();
      for (int i = 0; i < 4; i++) begin
        if (got.comp[i] !== exp.comp[i]) begin
          errors++;
          $display("%0t: out_%s expected %0d actual %0d",
                   $time, names[i], exp.comp[i], got.comp[i]);
        end
      end
      if (got.sat !== exp.sat) begin
        errors++;
        $display("%0t: out_saturated expected %0b actual %0b", $time, exp.sat, got.sat);
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  logic                           in_operation;
  logic signed [CW-1:0]           in_w;
  logic signed [CW-1:0]           in_x;
  logic signed [CW-1:0]           in_y;
  logic signed [CW-1:0]           in_z;
  logic                           out_valid;
  logic                           out_ready;
  logic signed [CW-1:0]           out_w;
  logic signed [CW-1:0]           out_x;
  logic signed [CW-1:0]           out_y;
  logic signed [CW-1:0]           out_z;
  logic                           out_saturated;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [qrm_pkg::ADDR_W-1:0]     paddr;
  logic [qrm_pkg::DATA_W-1:0]     pwdata;
  logic [qrm_pkg::DATA_W-1:0]     prdata;
  logic                           pready;

  quat_scoreboard sb = new();
  bit             calm;
  bit             hold_off_req;
  int             idle_pct;
  int             stall_pct;
  int             quiet_cycles;

  quaternion_rotate_and_multiply_unit #(
    .COMPONENT_WIDTH(CW)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_w         (in_w),
    .in_x         (in_x),
    .in_y         (in_y),
    .in_z         (in_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_w        (out_w),
    .out_x        (out_x),
    .out_y        (out_y),
    .out_z        (out_z),
    .out_saturated(out_saturated),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // transfer monitors: operands in, results out
  always @(posedge clk) begin
    logic signed [CW-1:0] operand [4];
    quat_result_t         got;
    if (rst_n && in_valid && in_ready) begin
      operand = '{in_w, in_x, in_y, in_z};
      sb.note_input(in_operation, operand);
    end
    if (rst_n && out_valid && out_ready) begin
      got.comp = '{out_w, out_x, out_y, out_z};
      got.sat = out_saturated;
      sb.check_result(got);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // one operand transfer, with an optional idle burst ahead of it
  task automatic send_quat(input logic op, input int w, input int x, input int y, input int z);
    if (!calm && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_w <= w[CW-1:0];
    in_x <= x[CW-1:0];
    in_y <= y[CW-1:0];
    in_z <= z[CW-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop offering and let every pending result drain
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (qrm_pkg::STAGES + 3) @(posedge clk);
  endtask

  // register write; upper data bits are junk the block must ignore
  task automatic write_reg(input logic [1:0] idx, input int value);
    logic [qrm_pkg::DATA_W-1:0] data;
    data = $urandom;
    data[CW-1:0] = value[CW-1:0];
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_component(idx, value[CW-1:0]);
  endtask

  task automatic set_quat(input int w, input int x, input int y, input int z);
    drain();
    write_reg(qrm_pkg::REG_Q_W, w);
    write_reg(qrm_pkg::REG_Q_X, x);
    write_reg(qrm_pkg::REG_Q_Y, y);
    write_reg(qrm_pkg::REG_Q_Z, z);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // mix of extremes, zero, small values and full-range values
  function automatic int rand_comp();
    logic [31:0] raw;
    int          v;
    raw = $urandom;
    v = int'($urandom_range(0, 511)) - 256;
    case ($urandom_range(0, 9))
      0: return int'(COMP_MIN);
      1: return int'(COMP_MAX);
      2: return 0;
      3, 4: return v;
      default: return int'($signed(raw[CW-1:0]));
    endcase
  endfunction

  function automatic int near_unit_comp();
    return int'($urandom_range(0, 18000)) - 9000;
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++)
      send_quat(1'($urandom_range(0, 1)), rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endtask

  // stimulus
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = qrm_pkg::OP_ROTATE;
    in_w = '0;
    in_x = '0;
    in_y = '0;
    in_z = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    hold_off_req = 1'b0;
    idle_pct = 20;
    stall_pct = 20;
    quiet_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity quaternion out of reset
    send_quat(qrm_pkg::OP_ROTATE, 12345, 32767, -32768, 1);
    send_quat(qrm_pkg::OP_MULTIPLY, 16384, -32768, 32767, 0);
    send_quat(qrm_pkg::OP_MULTIPLY, -32768, -32768, -32768, -32768);

    // tiny q: ties round toward plus infinity on multiply
    set_quat(1, 0, 0, 0);
    send_quat(qrm_pkg::OP_MULTIPLY, 8192, -8192, 24576, -24575);
    send_quat(qrm_pkg::OP_ROTATE, 0, 32767, -32768, 0);

    // half q: ties on rotate after the double shift
    set_quat(8192, 0, 0, 0);
    send_quat(qrm_pkg::OP_ROTATE, 0, 2, -2, 6);
    send_quat(qrm_pkg::OP_ROTATE, -1, -6, 1, -1);

    // quarter turn about z
    set_quat(11585, 0, 0, 11585);
    send_quat(qrm_pkg::OP_ROTATE, 0, 100, 0, 0);
    send_quat(qrm_pkg::OP_ROTATE, 0, 32767, 32767, 32767);
    send_quat(qrm_pkg::OP_ROTATE, 0, -32768, -32768, -32768);
    send_quat(qrm_pkg::OP_MULTIPLY, 32767, 32767, 32767, 32767);

    // non-unit q at the register extremes, saturation on both ops
    set_quat(32767, -32768, 32767, -32768);
    send_quat(qrm_pkg::OP_ROTATE, 0, 1, 1, 1);
    send_quat(qrm_pkg::OP_ROTATE, 0, -32768, 32767, -32768);
    send_quat(qrm_pkg::OP_MULTIPLY, -32768, -32768, -32768, -32768);
    send_quat(qrm_pkg::OP_MULTIPLY, 32767, -1, 0, 1);

    set_quat(-32768, -32768, -32768, -32768);
    send_quat(qrm_pkg::OP_ROTATE, 32767, -32768, -32768, -32768);
    send_quat(qrm_pkg::OP_MULTIPLY, -32768, -32768, -32768, -32768);
    send_quat(qrm_pkg::OP_MULTIPLY, 32767, 32767, 32767, 32767);

    // random phases, each with its own q and idling mix
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 2 == 0)
        set_quat(near_unit_comp(), near_unit_comp(), near_unit_comp(), near_unit_comp());
      else
        set_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
      idle_pct = (ph == 3) ? 0 : 20;
      stall_pct = (ph == 3) ? 0 : 25;
      if (ph == 1) hold_off_req = 1'b1;
      if (ph == 5) calm = 1'b1;
      run_random(155);
    end

    // wind down
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (qrm_pkg::STAGES + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
rtl/qrm_pkg.sv
rtl/qrm_quat_mult.sv
rtl/qrm_conj_mult.sv
rtl/qrm_round_sat.sv
rtl/quaternion_rotate_and_multiply_unit.sv
rtl/qrm_checker.sv
dv/tb_quaternion_rotate_and_multiply_unit.sv
